>>> rtl/yaz0_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yaz0_pkg: shared types and constants of the Yaz0 LZ decoder
// Status codes, controller states, token phases and history port bundles.
// ----------------------------------------------------------------------------
package yaz0_pkg;

  // History window: 4096 bytes, addressed by the low bits of the position
  localparam int unsigned WIN_AW    = 12;
  localparam int unsigned WIN_DEPTH = 1 << WIN_AW;

  // Header layout: 16 bytes, expanded size big-endian in bytes 4..7
  localparam logic [4:0] HDR_LEN    = 5'd16;
  localparam logic [4:0] SIZE_FIRST = 5'd4;
  localparam logic [4:0] SIZE_END   = 5'd8;

  // Run length biases of the short and the long back-reference form
  localparam logic [8:0] SHORT_BIAS = 9'd2;
  localparam logic [8:0] LONG_BIAS  = 9'd18;

  // First flag bit is the most significant one
  localparam logic [7:0] FLAG_FIRST = 8'h80;

  typedef enum logic [2:0] {
    STAT_RUNNING  = 3'd0,
    STAT_DONE     = 3'd1,
    STAT_SIZE_ERR = 3'd2,
    STAT_IN_SHORT = 3'd3,
    STAT_REF_ERR  = 3'd4,
    STAT_RUN_OVF  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_STREAM = 2'd0,
    S_COPY   = 2'd1,
    S_HALT   = 2'd2
  } dec_state_e;

  typedef enum logic [1:0] {
    PH_OP      = 2'd0,
    PH_CODE_LO = 2'd1,
    PH_LEN     = 2'd2
  } phase_e;

  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] addr;
    logic [7:0]        data;
  } hist_wr_t;

  typedef struct packed {
    logic              re;
    logic [WIN_AW-1:0] addr;
  } hist_rd_t;

endpackage
`default_nettype wire

>>> rtl/yaz0_hist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yaz0_hist: history window memory
// One write and one registered read per cycle. A read of the entry written
// in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
module yaz0_hist
  import yaz0_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire hist_wr_t wr_i,
  input  wire hist_rd_t rd_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [WIN_DEPTH];
  logic [7:0] rdata_q;
  logic [7:0] fwd_data_q;
  logic       fwd_hit_q;

  // Storage and read port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.re) begin
      rdata_q    <= mem[rd_i.addr];
      fwd_data_q <= wr_i.data;
    end
  end

  // Same-entry collision flag, held until the next read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_i.re) begin
      fwd_hit_q <= wr_i.we && (wr_i.addr == rd_i.addr);
    end
  end

  assign rdata_o = fwd_hit_q ? fwd_data_q : rdata_q;

endmodule
`default_nettype wire

>>> rtl/yaz0_lz_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yaz0_lz_decoder: Yaz0 stream decompressor
// Parses header, flag bytes, literals and back-references; emits packed words.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the compressed stream, one byte per request, tlast on the
//   final byte. m_axis returns decoded bytes up to BYTES_PER_RESULT per
//   request, a byte count, tlast on the final word caused by an input byte
//   and the decoder status in tuser (nonzero only on that final word).
//   expected_size is written through cfg_we_i / cfg_wdata_i while idle.
// Timing:
//   Header, flag, literal and code bytes are taken while the output register
//   is free; a literal's word enters the output register as the byte is taken.
//   A back-reference holds s_axis while it is copied: the history memory
//   gives one byte per cycle through its single read port unless m_axis
//   stalls, with a word appearing every BYTES_PER_RESULT bytes.
// Reset and stalls:
//   Reset clears position, header state and the halt state; history contents
//   are not cleared (a reference never reaches an unwritten entry). When m_axis
//   stalls, the output register holds, input stops and a copy waits at a word's
//   last byte. After a final status, input is drained and dropped until reset.
// ----------------------------------------------------------------------------
module yaz0_lz_decoder
  import yaz0_pkg::*;
#(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: expected_size
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // compressed input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // in_last
  // decoded output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [63:0] out_bytes, [67:64] out_count
  output logic             m_axis_tlast,   // run_last
  output logic [2:0]       m_axis_tuser    // [2:0] status
);

  localparam logic [3:0] BprCnt = 4'(BYTES_PER_RESULT);

  // Control and stream state
  dec_state_e  state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] total_q, total_d;
  logic [31:0] expected_q;
  logic [31:0] pos_q, pos_d;
  logic [7:0]  flag_byte_q, flag_byte_d;
  logic [7:0]  flag_mask_q, flag_mask_d;
  logic [15:0] code_q, code_d;
  logic        last_q, last_d;

  // Copy engine
  logic [WIN_AW-1:0] src_q, src_d;
  logic [8:0]        iss_q, iss_d;
  logic [8:0]        rem_q, rem_d;
  logic              rv_q, rv_d;

  // Word assembly and output register
  logic [63:0] asm_bytes_q, asm_bytes_d;
  logic [3:0]  asm_cnt_q, asm_cnt_d;
  logic        ov_q, ov_d;
  logic [63:0] obytes_q, obytes_d;
  logic [3:0]  ocnt_q, ocnt_d;
  logic        olast_q, olast_d;
  status_e     ostat_q, ostat_d;

  hist_wr_t   hwr;
  hist_rd_t   hrd;
  logic [7:0] hist_byte;

  // Scratch values of the decode step
  logic        out_free;
  logic        in_fire;
  status_e     stat_c;
  logic [15:0] code_c;
  logic [12:0] dist_c;
  logic [8:0]  len_c;
  logic        try_run;
  logic        absorb, issue, last_byte, full_c;
  logic [3:0]  new_cnt;
  logic [63:0] merged;
  logic [31:0] pos_inc;

  yaz0_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (hwr),
    .rd_i    (hrd),
    .rdata_o (hist_byte)
  );

  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_HALT) || ((state_q == S_STREAM) && out_free);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign pos_inc       = pos_q + 32'd1;

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    total_d     = total_q;
    pos_d       = pos_q;
    flag_byte_d = flag_byte_q;
    flag_mask_d = flag_mask_q;
    code_d      = code_q;
    last_d      = last_q;
    src_d       = src_q;
    iss_d       = iss_q;
    rem_d       = rem_q;
    rv_d        = rv_q;
    asm_bytes_d = asm_bytes_q;
    asm_cnt_d   = asm_cnt_q;
    ov_d        = ov_q && !m_axis_tready;
    obytes_d    = obytes_q;
    ocnt_d      = ocnt_q;
    olast_d     = olast_q;
    ostat_d     = ostat_q;
    hwr         = '{we: 1'b0, addr: pos_q[WIN_AW-1:0], data: s_axis_tdata};
    hrd         = '{re: 1'b0, addr: src_q};
    stat_c      = STAT_RUNNING;
    code_c      = {code_q[15:8], s_axis_tdata};
    dist_c      = 13'(code_q[11:0]) + 13'd1;
    len_c       = 9'(s_axis_tdata) + LONG_BIAS;
    try_run     = 1'b0;
    absorb      = 1'b0;
    issue       = 1'b0;
    last_byte   = (rem_q == 9'd1);
    new_cnt     = asm_cnt_q + 4'd1;
    full_c      = (new_cnt == BprCnt);
    merged      = asm_bytes_q | (64'(hist_byte) << {asm_cnt_q[2:0], 3'b000});

    unique case (state_q)
      S_STREAM: begin
        if (in_fire) begin
          if (hdr_cnt_q < HDR_LEN) begin
            // Header byte
            if (hdr_cnt_q >= SIZE_FIRST && hdr_cnt_q < SIZE_END) begin
              total_d = {total_q[23:0], s_axis_tdata};
            end
            hdr_cnt_d = hdr_cnt_q + 5'd1;
            if (hdr_cnt_q == HDR_LEN - 5'd1) begin
              if (total_q != expected_q) begin
                stat_c = STAT_SIZE_ERR;
              end else if (total_q == pos_q) begin
                stat_c = STAT_DONE;
              end
            end
          end else begin
            unique case (phase_q)
              PH_OP: begin
                if (flag_mask_q == 8'h00) begin
                  flag_byte_d = s_axis_tdata;
                  flag_mask_d = FLAG_FIRST;
                end else if ((flag_byte_q & flag_mask_q) != 8'h00) begin
                  // Literal byte
                  hwr.we      = 1'b1;
                  pos_d       = pos_inc;
                  flag_mask_d = flag_mask_q >> 1;
                  if (pos_inc == total_q) begin
                    stat_c = STAT_DONE;
                  end
                end else begin
                  code_d  = {s_axis_tdata, 8'h00};
                  phase_d = PH_CODE_LO;
                end
              end
              PH_CODE_LO: begin
                code_d = code_c;
                dist_c = 13'(code_c[11:0]) + 13'd1;
                if (32'(dist_c) > pos_q) begin
                  stat_c = STAT_REF_ERR;
                end else if (code_c[15:12] != 4'd0) begin
                  len_c   = 9'(code_c[15:12]) + SHORT_BIAS;
                  try_run = 1'b1;
                end else begin
                  phase_d = PH_LEN;
                end
              end
              PH_LEN: begin
                try_run = 1'b1;
              end
              default: begin
                phase_d = PH_OP;
              end
            endcase

            // Back-reference start: check room, then hand over to the copier
            if (try_run) begin
              if ((total_q - pos_q) < 32'(len_c)) begin
                stat_c = STAT_RUN_OVF;
              end else begin
                state_d     = S_COPY;
                flag_mask_d = flag_mask_q >> 1;
                phase_d     = PH_OP;
                src_d       = pos_q[WIN_AW-1:0] - dist_c[WIN_AW-1:0];
                iss_d       = len_c;
                rem_d       = len_c;
                rv_d        = 1'b0;
                last_d      = s_axis_tlast;
              end
            end
          end

          if (stat_c == STAT_RUNNING && s_axis_tlast && state_d != S_COPY) begin
            stat_c = STAT_IN_SHORT;
          end

          // Result of this byte, if any
          if (hwr.we) begin
            ov_d     = 1'b1;
            obytes_d = 64'(s_axis_tdata);
            ocnt_d   = 4'd1;
            olast_d  = 1'b1;
            ostat_d  = stat_c;
          end else if (stat_c != STAT_RUNNING) begin
            ov_d     = 1'b1;
            obytes_d = '0;
            ocnt_d   = 4'd0;
            olast_d  = 1'b1;
            ostat_d  = stat_c;
          end
          if (stat_c != STAT_RUNNING) begin
            state_d = S_HALT;
          end
        end
      end

      S_COPY: begin
        // Take the pending read byte, unless it completes a word that cannot go out
        absorb = rv_q && (out_free || (!full_c && !last_byte));
        issue  = (iss_q != 9'd0) && (!rv_q || absorb);
        hrd.re = issue;
        if (issue) begin
          src_d = src_q + WIN_AW'(1);
          iss_d = iss_q - 9'd1;
        end
        rv_d = issue || (rv_q && !absorb);

        if (absorb) begin
          hwr.we   = 1'b1;
          hwr.data = hist_byte;
          pos_d    = pos_inc;
          rem_d    = rem_q - 9'd1;
          if (last_byte) begin
            if (pos_inc == total_q) begin
              stat_c = STAT_DONE;
            end else if (last_q) begin
              stat_c = STAT_IN_SHORT;
            end
          end
          if (full_c || last_byte) begin
            ov_d        = 1'b1;
            obytes_d    = merged;
            ocnt_d      = new_cnt;
            olast_d     = last_byte;
            ostat_d     = stat_c;
            asm_bytes_d = '0;
            asm_cnt_d   = 4'd0;
          end else begin
            asm_bytes_d = merged;
            asm_cnt_d   = new_cnt;
          end
          if (last_byte) begin
            state_d = (stat_c != STAT_RUNNING) ? S_HALT : S_STREAM;
          end
        end
      end

      S_HALT: begin
        // Drop everything until reset
      end

      default: begin
        state_d = S_HALT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_STREAM;
      phase_q     <= PH_OP;
      hdr_cnt_q   <= '0;
      total_q     <= '0;
      expected_q  <= '0;
      pos_q       <= '0;
      flag_byte_q <= '0;
      flag_mask_q <= '0;
      code_q      <= '0;
      last_q      <= 1'b0;
      iss_q       <= '0;
      rem_q       <= '0;
      rv_q        <= 1'b0;
      asm_bytes_q <= '0;
      asm_cnt_q   <= '0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      total_q     <= total_d;
      pos_q       <= pos_d;
      flag_byte_q <= flag_byte_d;
      flag_mask_q <= flag_mask_d;
      code_q      <= code_d;
      last_q      <= last_d;
      iss_q       <= iss_d;
      rem_q       <= rem_d;
      rv_q        <= rv_d;
      asm_bytes_q <= asm_bytes_d;
      asm_cnt_q   <= asm_cnt_d;
      ov_q        <= ov_d;
      if (cfg_we_i) begin
        expected_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    obytes_q <= obytes_d;
    ocnt_q   <= ocnt_d;
    olast_q  <= olast_d;
    ostat_q  <= ostat_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0000, ocnt_q, obytes_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ostat_q;

endmodule
`default_nettype wire

>>> rtl/yaz0_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yaz0_chk: port-level checks of the Yaz0 decoder
// Watches the output stream for malformed words and stall violations.
// ----------------------------------------------------------------------------
module yaz0_chk
  import yaz0_pkg::*;
#(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [2:0]  m_axis_tuser
);

  localparam logic [3:0] BprCnt = 4'(BYTES_PER_RESULT);

  // A stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // A status is only reported on the final word of a request
  a_stat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STAT_RUNNING) |-> m_axis_tlast)
    else $error("status on a non-final word");

  // Non-final words are always full
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[67:64] == BprCnt)
    else $error("partial word before the end of a run");

  // An empty word only carries a status
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[67:64] == 4'd0) |->
      m_axis_tlast && (m_axis_tuser != STAT_RUNNING))
    else $error("empty word without status");

endmodule

bind yaz0_lz_decoder yaz0_chk #(.BYTES_PER_RESULT(BYTES_PER_RESULT)) u_yaz0_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

>>> tb/yaz0_lz_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaz0_lz_decoder_tb: self-checking bench for the Yaz0 stream decoder
// Builds one compressed stream with a known expanded length. The stream is a
// directed group of literals and runs, then random groups, then an ending
// picked at random. A scoreboard expands every accepted request and compares
// the decoded words field by field.
// ----------------------------------------------------------------------------
module yaz0_lz_decoder_tb
  import yaz0_pkg::*;
;

  localparam int unsigned WORD_BYTES    = 8;
  localparam int unsigned ITEM_GOAL     = 180;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned HOLD_AT       = 40;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned MAX_RUN_LEN   = 273;

  // How the stream ends
  typedef enum {
    END_DONE,
    END_SHORT,
    END_REF,
    END_OVF,
    END_SIZE,
    END_ZERO
  } stream_end_e;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    status_e     status;
  } out_word_t;

  // Expands accepted requests into decoded words and checks the output
  class yaz0_scoreboard;
    logic [7:0]  window [WIN_DEPTH];
    logic [31:0] pos;
    logic [31:0] size_hdr;
    logic [31:0] size_cfg;
    logic [4:0]  hdr_cnt;
    logic [7:0]  flags;
    logic [7:0]  mask;
    phase_e      phase;
    logic [15:0] code;
    status_e     fin;
    logic [7:0]  run_buf[$];
    out_word_t   due_words[$];
    int          errors;

    function new();
      pos      = '0;
      size_hdr = '0;
      size_cfg = '0;
      hdr_cnt  = '0;
      flags    = '0;
      mask     = '0;
      phase    = PH_OP;
      code     = '0;
      fin      = STAT_RUNNING;
      errors   = 0;
    endfunction

    function void set_size(logic [31:0] value);
      size_cfg = value;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void emit(logic [7:0] b);
      window[pos & (WIN_DEPTH - 1)] = b;
      run_buf.push_back(b);
      pos++;
    endfunction

    function status_e copy_run(int unsigned len, logic [31:0] ref_dist);
      if (size_hdr - pos < len) return STAT_RUN_OVF;
      for (int unsigned i = 0; i < len; i++)
        emit(window[(pos - ref_dist) & (WIN_DEPTH - 1)]);
      mask >>= 1;
      phase = PH_OP;
      return STAT_RUNNING;
    endfunction

    // One accepted input byte: update the decoder state, queue its words
    function void expand_request(logic [7:0] b, logic l);
      status_e     st;
      logic [31:0] ref_dist;
      int unsigned n;
      out_word_t   w;
      if (fin != STAT_RUNNING) return;
      st = STAT_RUNNING;
      run_buf.delete();
      if (hdr_cnt < HDR_LEN) begin
        if (hdr_cnt >= SIZE_FIRST && hdr_cnt < SIZE_END) size_hdr = {size_hdr[23:0], b};
        hdr_cnt++;
        if (hdr_cnt == HDR_LEN && size_hdr != size_cfg) st = STAT_SIZE_ERR;
      end else if (phase == PH_OP) begin
        if (mask == 0) begin
          flags = b;
          mask  = FLAG_FIRST;
        end else if ((flags & mask) != 0) begin
          emit(b);
          mask >>= 1;
        end else begin
          code  = {b, 8'h00};
          phase = PH_CODE_LO;
        end
      end else if (phase == PH_CODE_LO) begin
        code[7:0] = b;
        ref_dist = 32'(code[11:0]) + 32'd1;
        if (ref_dist > pos) st = STAT_REF_ERR;
        else if (code[15:12] != 0) st = copy_run(int'(code[15:12]) + SHORT_BIAS, ref_dist);
        else phase = PH_LEN;
      end else begin
        st = copy_run(int'(b) + LONG_BIAS, 32'(code[11:0]) + 32'd1);
      end

      if (st == STAT_RUNNING && hdr_cnt == HDR_LEN && pos == size_hdr) st = STAT_DONE;
      if (st == STAT_RUNNING && l) st = STAT_IN_SHORT;
      fin = st;

      // Pack into words; an ending with nothing decoded still gives one word
      n = (run_buf.size() + WORD_BYTES - 1) / WORD_BYTES;
      if (n == 0 && st != STAT_RUNNING) n = 1;
      for (int unsigned k = 0; k < n; k++) begin
        w.data  = '0;
        w.count = '0;
        for (int unsigned j = 0; j < WORD_BYTES; j++)
          if (k * WORD_BYTES + j < run_buf.size()) begin
            w.data[8*j +: 8] = run_buf[k * WORD_BYTES + j];
            w.count++;
          end
        w.last   = (k + 1 == n);
        w.status = (k + 1 == n) ? st : STAT_RUNNING;
        due_words.push_back(w);
      end
    endfunction

    function void check_word(logic [71:0] data, logic last, logic [2:0] user);
      out_word_t w;
      if (due_words.size() == 0) begin
        $error("unexpected word: out_bytes %h out_count %0d status %0d",
               data[63:0], data[67:64], user);
        errors++;
        return;
      end
      w = due_words.pop_front();
      if (data[63:0] !== w.data) begin
        $error("out_bytes: expected %h, actual %h", w.data, data[63:0]);
        errors++;
      end
      if (data[67:64] !== w.count) begin
        $error("out_count: expected %0d, actual %0d", w.count, data[67:64]);
        errors++;
      end
      if (last !== w.last) begin
        $error("run_last: expected %0b, actual %0b", w.last, last);
        errors++;
      end
      if (user !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, user);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        s_axis_tlast;   // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // [63:0] out_bytes, [67:64] out_count
  logic        m_axis_tlast;   // run_last
  logic [2:0]  m_axis_tuser;   // [2:0] status

  yaz0_scoreboard board = new();

  logic [7:0]  stream_q[$];
  logic        last_q[$];
  int unsigned plan_pos;
  int unsigned taken_count;
  bit          calm;

  yaz0_lz_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stream planning helpers; plan_pos tracks the expanded length so far
  function automatic void put_literal(logic [7:0] b);
    stream_q.push_back(b);
    plan_pos++;
  endfunction

  function automatic void put_ref(int unsigned len, int unsigned ref_dist);
    logic [11:0] d;
    d = 12'(ref_dist - 1);
    if (len < LONG_BIAS) begin
      stream_q.push_back({4'(len - SHORT_BIAS), d[11:8]});
      stream_q.push_back(d[7:0]);
    end else begin
      stream_q.push_back({4'h0, d[11:8]});
      stream_q.push_back(d[7:0]);
      stream_q.push_back(8'(len - LONG_BIAS));
    end
    plan_pos += len;
  endfunction

  // Distance biased to the nearest byte and the farthest reachable one
  function automatic int unsigned pick_dist();
    int unsigned span;
    span = (plan_pos < WIN_DEPTH) ? plan_pos : WIN_DEPTH;
    case ($urandom_range(0, 3))
      0:       return 1;
      1:       return span;
      default: return $urandom_range(1, span);
    endcase
  endfunction

  task automatic write_size(input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_size(value);
  endtask

  // Stop sending, let the decoder drain, then write the register
  task automatic settle_and_write(input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_size(value);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.expand_request(b, l);
    taken_count++;
  endtask

  // Sender: plans the stream, then feeds it
  initial begin
    int unsigned idx;
    int unsigned gap_pct;
    int unsigned k;
    int unsigned r;
    int unsigned len;
    int unsigned cut;
    int unsigned pause_idx;
    logic [31:0] hdr_size;
    logic [31:0] final_cfg;
    logic [7:0]  flag;
    stream_end_e ending;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    taken_count = 0;
    calm        = 1'b0;
    plan_pos    = 0;
    gap_pct     = 0;

    // Header with random filler; size bytes are patched in below
    repeat (HDR_LEN) stream_q.push_back(8'($urandom));

    // Directed group: slots lit, lit, four runs, lit, run
    stream_q.push_back(8'hC2);
    put_literal(8'h00);
    put_literal(8'hFF);
    put_ref(3, 1);                 // shortest run, repeats one byte
    put_ref(17, 2);                // longest short form
    put_ref(18, 1);                // shortest long form
    put_ref(MAX_RUN_LEN, plan_pos); // longest run, back to the first byte
    put_literal(8'($urandom));
    put_ref(4, plan_pos);

    // Random full groups
    while (stream_q.size() < ITEM_GOAL - 20) begin
      flag = 8'($urandom);
      stream_q.push_back(flag);
      for (int s = 7; s >= 0; s--)
        if (flag[s]) begin
          put_literal(8'($urandom));
        end else begin
          case ($urandom_range(0, 7))
            0:          len = MAX_RUN_LEN;
            1:          len = 3;
            2, 3, 4, 5: len = $urandom_range(3, 17);
            default:    len = $urandom_range(18, 60);
          endcase
          put_ref(len, pick_dist());
        end
    end

    case ($urandom_range(0, 11))
      0:       ending = END_SIZE;
      1:       ending = END_ZERO;
      2, 3, 4: ending = END_DONE;
      5, 6:    ending = END_SHORT;
      7, 8:    ending = END_REF;
      default: ending = END_OVF;
    endcase
    // A reference before the start needs a position inside the window
    if (ending == END_REF && plan_pos + 8 >= WIN_DEPTH) ending = END_SHORT;

    case (ending)
      END_SHORT: hdr_size = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                 : plan_pos + $urandom_range(1, 500);
      END_ZERO:  hdr_size = '0;
      END_REF, END_OVF: begin
        // Last group: some literals, then the bad reference
        k = $urandom_range(0, 7);
        flag = 8'($urandom);
        for (int s = 7; s > 7 - int'(k); s--) flag[s] = 1'b1;
        flag[7 - k] = 1'b0;
        stream_q.push_back(flag);
        repeat (k) put_literal(8'($urandom));
        if (ending == END_REF) begin
          hdr_size = plan_pos + $urandom_range(1, 1000);
          put_ref($urandom_range(3, MAX_RUN_LEN), plan_pos + 1);
        end else begin
          r = $urandom_range(1, 20);
          hdr_size = plan_pos + r;
          len = r + $urandom_range(1, 3);
          put_ref((len < 3) ? 3 : len, pick_dist());
        end
      end
      default:   hdr_size = plan_pos;
    endcase
    final_cfg = (ending == END_SIZE) ? hdr_size ^ (32'h1 << $urandom_range(0, 31)) : hdr_size;
    for (int i = 0; i < 4; i++) stream_q[SIZE_FIRST + i] = hdr_size[31 - 8*i -: 8];

    foreach (stream_q[i]) last_q.push_back(1'b0);
    if (ending == END_SHORT) begin
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, HDR_LEN - 1)
                                        : $urandom_range(HDR_LEN, stream_q.size() - 1);
      last_q[cut] = 1'b1;
    end else if (ending == END_DONE) begin
      last_q[last_q.size() - 1] = 1'($urandom);
    end
    // Trailing bytes after the end are dropped by the decoder
    repeat ($urandom_range(4, 10)) begin
      stream_q.push_back(8'($urandom));
      last_q.push_back(1'($urandom));
    end
    pause_idx = stream_q.size() / 2;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_size(32'hFFFF_FFFF);

    for (idx = 0; idx < stream_q.size(); idx++) begin
      calm = (idx >= stream_q.size() * 4 / 5);
      if (idx % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 20;
          default: gap_pct = 50;
        endcase
      end
      // Register updates mid-header and mid-stream; only the value at header end counts
      if (idx == 8) begin
        settle_and_write(32'h0);
      end else if (idx == 12) begin
        settle_and_write(final_cfg);
      end else if (idx == pause_idx) begin
        settle_and_write($urandom());
      end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      send_byte(stream_q[idx], last_q[idx]);
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    bit          held;
    int unsigned stall_pct;
    int unsigned seg;
    held      = 1'b0;
    stall_pct = 0;
    seg       = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (seg == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          default: stall_pct = 50;
        endcase
        seg = $urandom_range(10, 40);
      end
      seg--;
      if (!held && taken_count >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        for (int unsigned c = 0; c < LONG_HOLD; c++) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Watchdog
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
